/* hw/rtl/spfs_pkg.sv */
// ----------------------------------------------------------------------------
// spfs_pkg
// Shared types and constants for the smallest-prime-factor sieve unit.
// ----------------------------------------------------------------------------
package spfs_pkg;

    localparam int TABLE_SIZE_DEF = 65536;
    localparam int QUERY_W        = 16;
    localparam int FACTOR_W       = 16;

    typedef enum logic [2:0] {
        S_FILL,
        S_BASE_RD,
        S_BASE_CHK,
        S_MULT,
        S_DONE
    } t_bld_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic done;
    } t_bld_ctl;

endpackage

/* hw/rtl/smallest_prime_factor_sieve_unit.sv */
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve_unit
// Smallest-prime-factor lookup built by a sieve into one table RAM.
//
// After reset the unit holds busy high while it builds the table: one pass
// writes each entry (its own index, or 2 for even entries from 4), then the
// sieve visits each odd base whose square is below TABLE_SIZE and, for each
// prime base, every odd multiple from its square, then closes that base; the
// read of a multiple overlaps the write-back of the one before it. Then the
// build finishes.
// Once busy drops, a query is taken on every cycle with start high; the
// table read port sets one query per cycle. Each result is registered out
// to o_smallest_factor and o_is_prime after the table read, marked by o_strobe
// for one cycle. Results cannot be held off; they stream in query order.
// Queries at or beyond TABLE_SIZE return factor 0 and no prime flag.
// Reset restarts the build; no item is taken until it completes.
// ----------------------------------------------------------------------------
module smallest_prime_factor_sieve_unit #(
    parameter int TABLE_SIZE = spfs_pkg::TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spfs_pkg::QUERY_W-1:0]  i_query_value,
    output logic                          o_strobe,
    output logic [spfs_pkg::FACTOR_W-1:0] o_smallest_factor,
    output logic                          o_is_prime
);

    localparam int AW = $clog2(TABLE_SIZE);

    spfs_pkg::t_bld_ctl bld_ctl;
    logic [AW-1:0]      bld_raddr;
    logic [AW-1:0]      bld_waddr;
    logic [AW-1:0]      bld_wdata;
    logic [AW-1:0]      q_raddr;
    logic [AW-1:0]      ram_raddr;
    logic [AW-1:0]      ram_rdata;
    logic               ram_re;
    logic               acc;

    assign busy      = !bld_ctl.done;
    assign acc       = start && bld_ctl.done;
    assign ram_re    = bld_ctl.done ? acc : bld_ctl.rd_en;
    assign ram_raddr = bld_ctl.done ? q_raddr : bld_raddr;

    spfs_ram #(
        .WIDTH (AW),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (bld_ctl.wr_en),
        .i_waddr (bld_waddr),
        .i_wdata (bld_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    spfs_builder #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rdata (ram_rdata),
        .o_ctl   (bld_ctl),
        .o_raddr (bld_raddr),
        .o_waddr (bld_waddr),
        .o_wdata (bld_wdata)
    );

    spfs_query #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_query (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_acc             (acc),
        .i_query_value     (i_query_value),
        .i_rdata           (ram_rdata),
        .o_raddr           (q_raddr),
        .o_strobe          (o_strobe),
        .o_smallest_factor (o_smallest_factor),
        .o_is_prime        (o_is_prime)
    );

endmodule

/* hw/rtl/spfs_ram.sv */
// ----------------------------------------------------------------------------
// spfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/spfs_builder.sv */
// ----------------------------------------------------------------------------
// spfs_builder
// Sieve sequencer: fills the factor table, then marks odd composites with
// their smallest odd prime factor by read-modify-write through the RAM.
// ----------------------------------------------------------------------------
module spfs_builder #(
    parameter int TABLE_SIZE = spfs_pkg::TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(TABLE_SIZE)-1:0] i_rdata,
    output spfs_pkg::t_bld_ctl            o_ctl,
    output logic [$clog2(TABLE_SIZE)-1:0] o_raddr,
    output logic [$clog2(TABLE_SIZE)-1:0] o_waddr,
    output logic [$clog2(TABLE_SIZE)-1:0] o_wdata
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int BW = (AW + 1) / 2 + 1;

    spfs_pkg::t_bld_state r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [BW-1:0] r_base, n_base;
    logic [AW:0]   r_sq, n_sq;
    logic [AW:0]   r_mult, n_mult;
    logic [BW:0]   r_step, n_step;
    logic          r_wpend, n_wpend;
    logic [AW-1:0] r_waddr, n_waddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spfs_pkg::S_FILL;
            r_cnt   <= '0;
            r_base  <= BW'(3);
            r_sq    <= (AW+1)'(9);
            r_wpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_base  <= n_base;
            r_sq    <= n_sq;
            r_wpend <= n_wpend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mult  <= n_mult;
        r_step  <= n_step;
        r_waddr <= n_waddr;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_base  = r_base;
        n_sq    = r_sq;
        n_mult  = r_mult;
        n_step  = r_step;
        n_wpend = 1'b0;
        n_waddr = r_waddr;
        o_ctl   = '0;
        o_raddr = r_mult[AW-1:0];
        o_waddr = r_waddr;
        o_wdata = AW'(r_base);

        if (r_wpend && (i_rdata == r_waddr)) begin
            o_ctl.wr_en = 1'b1;
        end

        unique case (r_state)
            spfs_pkg::S_FILL: begin
                o_ctl.wr_en = 1'b1;
                o_waddr     = r_cnt;
                o_wdata     = (!r_cnt[0] && (r_cnt >= AW'(4))) ? AW'(2) : r_cnt;
                n_cnt       = r_cnt + AW'(1);
                if (&r_cnt) begin
                    n_state = spfs_pkg::S_BASE_RD;
                end
            end
            spfs_pkg::S_BASE_RD: begin
                if (r_sq[AW]) begin
                    n_state = spfs_pkg::S_DONE;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    o_raddr     = AW'(r_base);
                    n_state     = spfs_pkg::S_BASE_CHK;
                end
            end
            spfs_pkg::S_BASE_CHK: begin
                if (i_rdata == AW'(r_base)) begin
                    n_mult  = r_sq;
                    n_step  = {r_base, 1'b0};
                    n_state = spfs_pkg::S_MULT;
                end else begin
                    n_base  = r_base + BW'(2);
                    n_sq    = r_sq + (AW+1)'({r_base, 2'b00}) + (AW+1)'(4);
                    n_state = spfs_pkg::S_BASE_RD;
                end
            end
            spfs_pkg::S_MULT: begin
                if (!r_mult[AW]) begin
                    o_ctl.rd_en = 1'b1;
                    n_wpend     = 1'b1;
                    n_waddr     = r_mult[AW-1:0];
                    n_mult      = r_mult + (AW+1)'(r_step);
                end else begin
                    n_base  = r_base + BW'(2);
                    n_sq    = r_sq + (AW+1)'({r_base, 2'b00}) + (AW+1)'(4);
                    n_state = spfs_pkg::S_BASE_RD;
                end
            end
            spfs_pkg::S_DONE: begin
                o_ctl.done = 1'b1;
            end
            default: begin
                n_state = spfs_pkg::S_FILL;
            end
        endcase
    end

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spfs_pkg::S_DONE) |=> (r_state == spfs_pkg::S_DONE))
        else $error("build left done state");

    a_base_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base[0])
        else $error("sieve base is even");

    a_wpend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> ($past(r_state) == spfs_pkg::S_MULT))
        else $error("pending write without multiple read");

    a_no_rd_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spfs_pkg::S_FILL) |-> !o_ctl.rd_en && !r_wpend)
        else $error("read during table fill");

endmodule

/* hw/rtl/spfs_query.sv */
// ----------------------------------------------------------------------------
// spfs_query
// Query pipeline: table read, then factor and prime flag registered out.
// ----------------------------------------------------------------------------
module spfs_query #(
    parameter int TABLE_SIZE = spfs_pkg::TABLE_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic [spfs_pkg::QUERY_W-1:0]      i_query_value,
    input  logic [$clog2(TABLE_SIZE)-1:0]     i_rdata,
    output logic [$clog2(TABLE_SIZE)-1:0]     o_raddr,
    output logic                              o_strobe,
    output logic [spfs_pkg::FACTOR_W-1:0]     o_smallest_factor,
    output logic                              o_is_prime
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int XW = (AW > spfs_pkg::QUERY_W) ? AW : spfs_pkg::QUERY_W;

    logic [XW:0]                      qx;
    logic                             r_vld1;
    logic                             r_inr1;
    logic [spfs_pkg::QUERY_W-1:0]     r_q1;
    logic                             r_vld2;
    logic [spfs_pkg::FACTOR_W-1:0]    r_fac, n_fac;
    logic                             r_prime, n_prime;

    assign qx      = (XW+1)'(i_query_value);
    assign o_raddr = qx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_acc;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1    <= i_query_value;
        r_inr1  <= (qx < (XW+1)'(TABLE_SIZE));
        r_fac   <= n_fac;
        r_prime <= n_prime;
    end

    always_comb begin
        n_fac   = r_inr1 ? spfs_pkg::FACTOR_W'(i_rdata) : '0;
        n_prime = r_inr1 && ((XW+1)'(i_rdata) == (XW+1)'(r_q1))
                  && (r_q1 >= spfs_pkg::QUERY_W'(2));
    end

    assign o_strobe          = r_vld2;
    assign o_smallest_factor = r_fac;
    assign o_is_prime        = r_prime;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n, 1) && $past(i_rst_n, 2)) |-> (o_strobe == $past(i_acc, 2)))
        else $error("result strobe does not follow accepted item");

    a_prime_fac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_prime) |-> (o_smallest_factor >= spfs_pkg::FACTOR_W'(2)))
        else $error("prime flag with factor below two");

    a_prime_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_prime) |-> (o_smallest_factor == $past(r_q1)))
        else $error("prime flag with factor other than value");

endmodule

/* test/smallest_prime_factor_sieve_unit_tb.sv */
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve_unit_tb
// Self-checking bench for the smallest-prime-factor sieve unit.
//
// Waits out the table build after reset, then sends factor queries: first a
// short table of edge values (0, 1, small primes, squares of sieve bases,
// the top of the range), then random queries weighted toward the low and
// high ends. A local copy of the sieve predicts each result not typed in the
// table; each strobed result is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module smallest_prime_factor_sieve_unit_tb;

    localparam int TABLE_SIZE    = spfs_pkg::TABLE_SIZE_DEF;
    localparam int NUM_RANDOM    = 900;
    localparam int STALL_LIMIT   = 600000;
    localparam int NUM_DIRECTED  = 20;

    typedef struct packed {
        logic [spfs_pkg::QUERY_W-1:0]  value;
        logic [spfs_pkg::FACTOR_W-1:0] factor;
        logic                          prime;
    } t_spf_result;

    typedef struct packed {
        logic [spfs_pkg::QUERY_W-1:0]  value;
        logic                          typed;
        logic [spfs_pkg::FACTOR_W-1:0] factor;
        logic                          prime;
    } t_query_row;

    localparam t_query_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{16'd0,     1'b1, 16'd0,     1'b0},
        '{16'd1,     1'b1, 16'd1,     1'b0},
        '{16'd2,     1'b1, 16'd2,     1'b1},
        '{16'd3,     1'b1, 16'd3,     1'b1},
        '{16'd4,     1'b1, 16'd2,     1'b0},
        '{16'hFFFF,  1'b1, 16'd3,     1'b0},
        '{16'hFFFE,  1'b1, 16'd2,     1'b0},
        '{16'h8000,  1'b1, 16'd2,     1'b0},
        '{16'hAAAA,  1'b1, 16'd2,     1'b0},
        '{16'h5555,  1'b0, 16'd0,     1'b0},
        '{16'd65521, 1'b0, 16'd0,     1'b0},
        '{16'd63001, 1'b0, 16'd0,     1'b0},
        '{16'h7FFF,  1'b0, 16'd0,     1'b0},
        '{16'd9,     1'b0, 16'd0,     1'b0},
        '{16'd25,    1'b0, 16'd0,     1'b0},
        '{16'd49,    1'b0, 16'd0,     1'b0},
        '{16'd97,    1'b0, 16'd0,     1'b0},
        '{16'd64009, 1'b0, 16'd0,     1'b0},
        '{16'd58081, 1'b0, 16'd0,     1'b0},
        '{16'd65025, 1'b0, 16'd0,     1'b0}
    };

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          start          = 1'b0;
    logic [spfs_pkg::QUERY_W-1:0]  i_query_value  = '0;
    logic                          busy;
    logic                          o_strobe;
    logic [spfs_pkg::FACTOR_W-1:0] o_smallest_factor;
    logic                          o_is_prime;

    int unsigned spf_table [TABLE_SIZE];
    t_spf_result pending_spf [$];
    int          mismatch_count = 0;
    int          stall_cycles   = 0;

    smallest_prime_factor_sieve_unit #(
        .TABLE_SIZE(TABLE_SIZE)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_query_value    (i_query_value),
        .o_strobe         (o_strobe),
        .o_smallest_factor(o_smallest_factor),
        .o_is_prime       (o_is_prime)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void build_spf_table();
        int unsigned k;
        int unsigned b;
        int unsigned m;
        for (k = 0; k < TABLE_SIZE; k++)
            spf_table[k] = k;
        for (k = 4; k < TABLE_SIZE; k += 2)
            spf_table[k] = 2;
        for (b = 3; longint'(b) * b < TABLE_SIZE; b += 2) begin
            if (spf_table[b] == b) begin
                for (m = b * b; m < TABLE_SIZE; m += b) begin
                    if (spf_table[m] == m)
                        spf_table[m] = b;
                end
            end
        end
    endfunction

    function automatic t_spf_result predict_spf(logic [spfs_pkg::QUERY_W-1:0] v);
        t_spf_result r;
        r.value  = v;
        r.factor = '0;
        r.prime  = 1'b0;
        if (int'(v) < TABLE_SIZE) begin
            r.factor = spfs_pkg::FACTOR_W'(spf_table[v]);
            r.prime  = (spf_table[v] == v) && (v >= 2);
        end
        return r;
    endfunction

    function automatic logic [spfs_pkg::QUERY_W-1:0] pick_query_value();
        case ($urandom_range(0, 3))
            0: return spfs_pkg::QUERY_W'($urandom_range(0, 300));
            1: return spfs_pkg::QUERY_W'($urandom_range(65000, 65535));
            default: return spfs_pkg::QUERY_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // hold start until the item is taken, then record its prediction
    task automatic send_query(logic [spfs_pkg::QUERY_W-1:0] v, t_spf_result expected);
        start         <= 1'b1;
        i_query_value <= v;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_spf = {pending_spf, expected};
    endtask

    task automatic idle_sender(int cycles);
        start         <= 1'b0;
        i_query_value <= spfs_pkg::QUERY_W'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_spf.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_spf_result exp_r;
        if (o_strobe) begin
            if (pending_spf.size() == 0) begin
                $display("%0t: unexpected result factor %0d prime %0b",
                         $time, o_smallest_factor, o_is_prime);
                mismatch_count++;
            end else begin
                exp_r = pending_spf.pop_front();
                if (o_smallest_factor !== exp_r.factor) begin
                    $display("%0t: query %0d factor expected %0d, actual %0d",
                             $time, exp_r.value, exp_r.factor, o_smallest_factor);
                    mismatch_count++;
                end
                if (o_is_prime !== exp_r.prime) begin
                    $display("%0t: query %0d prime expected %0b, actual %0b",
                             $time, exp_r.value, exp_r.prime, o_is_prime);
                    mismatch_count++;
                end
            end
        end
        if ((i_rst_n && start && !busy) || o_strobe) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        t_spf_result                  exp_r;
        t_query_row                   row;
        logic [spfs_pkg::QUERY_W-1:0] v;
        build_spf_table();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NUM_DIRECTED; n++) begin
            row = DIRECTED_ROWS[n];
            if (row.typed) begin
                exp_r.value  = row.value;
                exp_r.factor = row.factor;
                exp_r.prime  = row.prime;
            end else begin
                exp_r = predict_spf(row.value);
            end
            if ($urandom_range(0, 99) < 9)
                idle_sender($urandom_range(1, 3));
            send_query(row.value, exp_r);
        end
        drain_results();

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 700)
                drain_results();
            if (!(n >= 300 && n < 550) && $urandom_range(0, 99) < 9)
                idle_sender($urandom_range(1, 3));
            v = pick_query_value();
            send_query(v, predict_spf(v));
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_spf.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
